// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define LMAD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lmad assertion failed");

// property checked at every edge, reset included
`define LMAD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lmad assertion failed");

`endif

// ===== sv/lmad_pkg.sv =====
// types, constants and small helpers of the light meter averaging display
// no dependencies
`timescale 1ns / 1ps

package lmad_pkg;

   localparam int WORD_W    = 16;
   localparam int EXP_W     = 4;
   localparam int MANT_W    = 12;
   localparam int READING_W = 18;
   localparam int LIMIT_W   = 14;
   localparam int DIGIT_W   = 4;
   localparam int SHOWN_W   = 14;
   localparam int TWO_DIG_W = 7;

   localparam int AVG_SAMPLES_DEF = 4;
   localparam int QUEUE_DEPTH_DEF = 8;

   // front pipeline registers holding items not yet in the queue
   localparam int INFLIGHT_W = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   // register index lives in the word-address bit
   localparam logic CSR_INDEX_LIMIT = 1'b0;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10000);
   localparam logic [SHOWN_W-1:0] SHOWN_MAX   = SHOWN_W'(9999);

   // mantissa*3 << exponent, divided by 4 then by 625
   localparam int TRIPLE_W   = MANT_W + 2;
   localparam int WIDE_W     = TRIPLE_W + (1 << EXP_W) - 1;
   localparam int SCALED_W   = WIDE_W - 2;
   localparam int CONV_SHIFT = SCALED_W + 10;
   localparam longint unsigned CONV_DIV = 625;
   localparam longint unsigned CONV_MULT_L =
      ((64'd1 << CONV_SHIFT) + CONV_DIV - 1) / CONV_DIV;
   localparam int CONV_MULT_W = 28;
   localparam logic [CONV_MULT_W-1:0] CONV_MULT = CONV_MULT_W'(CONV_MULT_L);

   // shown / 100 for shown below 2^14
   localparam int HUND_SHIFT = SHOWN_W + 7;
   localparam longint unsigned HUND_MULT_L = ((64'd1 << HUND_SHIFT) + 99) / 100;
   localparam int HUND_MULT_W = 15;
   localparam logic [HUND_MULT_W-1:0] HUND_MULT = HUND_MULT_W'(HUND_MULT_L);

   typedef struct packed {
      logic [READING_W-1:0] held;
      logic                 mode_b;
   } lmad_entry_type;

   typedef struct packed {
      logic           valid;
      lmad_entry_type entry;
   } lmad_push_type;

   typedef struct packed {
      logic empty;
      logic no_room;
   } lmad_qstat_type;

   // tens digit of a value below 100
   function automatic logic [DIGIT_W-1:0] tens_of(input logic [TWO_DIG_W-1:0] v);
      logic [14:0] p;
      p = 15'(v) * 15'd205;
      return p[14:11];
   endfunction

   // units digit of a value below 100
   function automatic logic [DIGIT_W-1:0] units_of(input logic [TWO_DIG_W-1:0] v);
      logic [TWO_DIG_W-1:0] t;
      logic [TWO_DIG_W-1:0] u;
      t = TWO_DIG_W'(tens_of(v));
      u = v - TWO_DIG_W'(t * TWO_DIG_W'(10));
      return u[DIGIT_W-1:0];
   endfunction

endpackage

// ===== sv/lmad_front.sv =====
// front part: accepts items, converts the sensor word and forms block means
// depends on lmad_pkg
`timescale 1ns / 1ps

module lmad_front #(
   parameter int AVG_SAMPLES = lmad_pkg::AVG_SAMPLES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_accept,
   input  logic [lmad_pkg::WORD_W-1:0]         sensor_word,
   input  logic                                mode_b,
   output lmad_pkg::lmad_push_type             push,
   output logic [lmad_pkg::INFLIGHT_W-1:0]     inflight
);

   localparam int LOG_N       = $clog2(AVG_SAMPLES);
   localparam int CNT_W       = LOG_N;
   localparam int SUM_W       = lmad_pkg::READING_W + LOG_N;
   localparam int MEAN_SHIFT  = SUM_W + LOG_N;
   localparam int MEAN_MULT_W = SUM_W + 1;
   localparam int MEAN_PROD_W = SUM_W + MEAN_MULT_W;
   localparam longint unsigned MEAN_MULT_L =
      ((64'd1 << MEAN_SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES;
   localparam logic [MEAN_MULT_W-1:0] MEAN_MULT = MEAN_MULT_W'(MEAN_MULT_L);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(AVG_SAMPLES - 1);
   localparam int CONV_PROD_W = lmad_pkg::SCALED_W + lmad_pkg::CONV_MULT_W;

   // stage 1: scaled raw value
   logic                              v1_ff, v1_in;
   logic                              mode1_ff;
   logic [lmad_pkg::SCALED_W-1:0]     scaled_ff, scaled_in;
   // stage 2: converted sample
   logic                              v2_ff, v2_in;
   logic                              mode2_ff;
   logic [lmad_pkg::READING_W-1:0]    sample_ff, sample_in;
   // stage 3: group total
   logic                              v3_ff, v3_in;
   logic                              mode3_ff;
   logic                              last_ff, last_in;
   logic [SUM_W-1:0]                  total_ff, total_in;
   logic [SUM_W-1:0]                  acc_ff, acc_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [lmad_pkg::READING_W-1:0]    held_ff, held_in;

   logic [lmad_pkg::EXP_W-1:0]        expo;
   logic [lmad_pkg::TRIPLE_W-1:0]     tripled;
   logic [lmad_pkg::WIDE_W-1:0]       widened;
   logic [CONV_PROD_W-1:0]            conv_prod;
   logic [MEAN_PROD_W-1:0]            mean_prod;

   always_comb begin
      expo      = sensor_word[lmad_pkg::WORD_W-1 -: lmad_pkg::EXP_W];
      tripled   = lmad_pkg::TRIPLE_W'(sensor_word[lmad_pkg::MANT_W-1:0])
                  * lmad_pkg::TRIPLE_W'(3);
      widened   = lmad_pkg::WIDE_W'(tripled) << expo;
      scaled_in = widened[lmad_pkg::WIDE_W-1:2];
      v1_in     = in_accept;

      conv_prod = CONV_PROD_W'(scaled_ff) * CONV_PROD_W'(lmad_pkg::CONV_MULT);
      sample_in = conv_prod[lmad_pkg::CONV_SHIFT +: lmad_pkg::READING_W];
      v2_in     = v1_ff;

      total_in = acc_ff + SUM_W'(sample_ff);
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      last_in  = 1'b0;
      if (v2_ff) begin
         if (cnt_ff == LAST_CNT) begin
            last_in = 1'b1;
            acc_in  = '0;
            cnt_in  = '0;
         end else begin
            acc_in = total_in;
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
      v3_in = v2_ff;

      mean_prod = MEAN_PROD_W'(total_ff) * MEAN_PROD_W'(MEAN_MULT);
      held_in   = (v3_ff && last_ff) ? mean_prod[MEAN_SHIFT +: lmad_pkg::READING_W]
                                     : held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         held_ff <= '0;
      end else begin
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
      mode1_ff  <= mode_b;
      sample_ff <= sample_in;
      mode2_ff  <= mode1_ff;
      total_ff  <= total_in;
      last_ff   <= last_in;
      mode3_ff  <= mode2_ff;
   end

   always_comb begin
      push.valid         = v3_ff;
      push.entry.held    = held_in;
      push.entry.mode_b  = mode3_ff;
      inflight = lmad_pkg::INFLIGHT_W'(v1_ff) + lmad_pkg::INFLIGHT_W'(v2_ff)
                 + lmad_pkg::INFLIGHT_W'(v3_ff);
   end

endmodule

// ===== sv/lmad_queue.sv =====
// short queue between the front and back parts
// depends on lmad_pkg
`timescale 1ns / 1ps

module lmad_queue #(
   parameter int DEPTH = lmad_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lmad_pkg::lmad_push_type           push,
   input  logic [lmad_pkg::INFLIGHT_W-1:0]   reserved,
   input  logic                              pop,
   output lmad_pkg::lmad_entry_type          head,
   output lmad_pkg::lmad_qstat_type          status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + lmad_pkg::INFLIGHT_W;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   lmad_pkg::lmad_entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] committed;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
      committed      = SUM_W'(count_ff) + SUM_W'(reserved);
      status.empty   = (count_ff == '0);
      status.no_room = (committed >= SUM_W'(DEPTH));
      head           = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// ===== sv/lmad_back.sv =====
// back part: overload check, mode scaling and bcd digits of the held reading
// depends on lmad_pkg
`timescale 1ns / 1ps

module lmad_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [lmad_pkg::LIMIT_W-1:0]       limit,
   input  lmad_pkg::lmad_entry_type           head,
   input  lmad_pkg::lmad_qstat_type           status,
   output logic                               pop,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [lmad_pkg::DIGIT_W-1:0]       rsp_digit_thousands,
   output logic [lmad_pkg::DIGIT_W-1:0]       rsp_digit_hundreds,
   output logic [lmad_pkg::DIGIT_W-1:0]       rsp_digit_tens,
   output logic [lmad_pkg::DIGIT_W-1:0]       rsp_digit_units,
   output logic                               rsp_decimal_point,
   output logic                               rsp_overload
);

   localparam int HUND_PROD_W = lmad_pkg::SHOWN_W + lmad_pkg::HUND_MULT_W;

   logic advance;

   // stage 1: shown value
   logic                             v1_ff, v1_in;
   logic                             ovl1_ff, ovl1_in;
   logic                             mode1_ff;
   logic [lmad_pkg::SHOWN_W-1:0]     shown1_ff, shown1_in;
   // stage 2: hundreds quotient
   logic                             v2_ff;
   logic                             ovl2_ff;
   logic                             mode2_ff;
   logic [lmad_pkg::SHOWN_W-1:0]     shown2_ff;
   logic [lmad_pkg::TWO_DIG_W-1:0]   hund_ff, hund_in;
   // output register
   logic                             out_v_ff;
   logic [lmad_pkg::DIGIT_W-1:0]     th_ff, th_in;
   logic [lmad_pkg::DIGIT_W-1:0]     hu_ff, hu_in;
   logic [lmad_pkg::DIGIT_W-1:0]     te_ff, te_in;
   logic [lmad_pkg::DIGIT_W-1:0]     un_ff, un_in;
   logic                             dp_ff, dp_in;
   logic                             ovl_ff;

   logic [lmad_pkg::READING_W-1:0]   scaled;
   logic [HUND_PROD_W-1:0]           hund_prod;
   logic [lmad_pkg::SHOWN_W-1:0]     rem_wide;
   logic [lmad_pkg::TWO_DIG_W-1:0]   rem;

   always_comb begin
      advance = !out_v_ff || !rsp_stall;
      pop     = advance && !status.empty;
      v1_in   = pop;

      ovl1_in   = head.held >= lmad_pkg::READING_W'(limit);
      scaled    = head.mode_b ? head.held : (head.held >> 1);
      shown1_in = (scaled > lmad_pkg::READING_W'(lmad_pkg::SHOWN_MAX))
                  ? lmad_pkg::SHOWN_MAX : scaled[lmad_pkg::SHOWN_W-1:0];

      hund_prod = HUND_PROD_W'(shown1_ff) * HUND_PROD_W'(lmad_pkg::HUND_MULT);
      hund_in   = hund_prod[lmad_pkg::HUND_SHIFT +: lmad_pkg::TWO_DIG_W];

      rem_wide = shown2_ff - lmad_pkg::SHOWN_W'(hund_ff) * lmad_pkg::SHOWN_W'(100);
      rem      = rem_wide[lmad_pkg::TWO_DIG_W-1:0];
      if (ovl2_ff) begin
         th_in = '0;
         hu_in = '0;
         te_in = '0;
         un_in = '0;
         dp_in = 1'b0;
      end else begin
         th_in = lmad_pkg::tens_of(hund_ff);
         hu_in = lmad_pkg::units_of(hund_ff);
         te_in = lmad_pkg::tens_of(rem);
         un_in = lmad_pkg::units_of(rem);
         dp_in = !mode2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (advance) begin
         v1_ff    <= v1_in;
         v2_ff    <= v1_ff;
         out_v_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ovl1_ff   <= ovl1_in;
         mode1_ff  <= head.mode_b;
         shown1_ff <= shown1_in;
         ovl2_ff   <= ovl1_ff;
         mode2_ff  <= mode1_ff;
         shown2_ff <= shown1_ff;
         hund_ff   <= hund_in;
         th_ff     <= th_in;
         hu_ff     <= hu_in;
         te_ff     <= te_in;
         un_ff     <= un_in;
         dp_ff     <= dp_in;
         ovl_ff    <= ovl2_ff;
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_digit_thousands = th_ff;
   assign rsp_digit_hundreds  = hu_ff;
   assign rsp_digit_tens      = te_ff;
   assign rsp_digit_units     = un_ff;
   assign rsp_decimal_point   = dp_ff;
   assign rsp_overload        = ovl_ff;

endmodule

// ===== sv/light_meter_average_display_core.sv =====
// Light meter core: each item is a raw sensor word (exponent in bits 15-12,
// mantissa in 11-0) plus a display mode; it is converted to uW/cm2, groups of
// AVG_SAMPLES samples set the held reading by their mean, and every item
// returns the held reading as four bcd digits with decimal point and overload
// flags. One item is taken per clock cycle while req_stall is low; its result
// passes through three front stages, the first loaded at the accepting edge,
// then the queue and then three back stages on its way to the output.
// The input stalls only when the queue plus the front stages hold
// QUEUE_DEPTH items, which happens only after the result side has stalled.
// The overload limit register sits at byte address 0, reset value 10000.
`timescale 1ns / 1ps

module light_meter_average_display_core #(
   parameter int AVG_SAMPLES = lmad_pkg::AVG_SAMPLES_DEF,
   parameter int QUEUE_DEPTH = lmad_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lmad_pkg::WORD_W-1:0]         req_sensor_word,
   input  logic                                req_mode_b,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lmad_pkg::DIGIT_W-1:0]        rsp_digit_thousands,
   output logic [lmad_pkg::DIGIT_W-1:0]        rsp_digit_hundreds,
   output logic [lmad_pkg::DIGIT_W-1:0]        rsp_digit_tens,
   output logic [lmad_pkg::DIGIT_W-1:0]        rsp_digit_units,
   output logic                                rsp_decimal_point,
   output logic                                rsp_overload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lmad_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lmad_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lmad_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   lmad_pkg::lmad_push_type             push;
   lmad_pkg::lmad_entry_type            head;
   lmad_pkg::lmad_qstat_type            status;
   logic [lmad_pkg::INFLIGHT_W-1:0]     inflight;
   logic                                pop;
   logic                                in_accept;
   logic                                limit_hit;
   logic [lmad_pkg::LIMIT_W-1:0]        limit_ff, limit_in;

   always_comb begin
      req_stall = status.no_room;
      in_accept = req_valid && !req_stall;
      pready    = 1'b1;
      limit_hit = paddr[2] == lmad_pkg::CSR_INDEX_LIMIT;
      limit_in  = limit_ff;
      if (psel && penable && pwrite && limit_hit) begin
         limit_in = pwdata[lmad_pkg::LIMIT_W-1:0];
      end
      prdata = limit_hit ? lmad_pkg::CSR_DATA_W'(limit_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= lmad_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   lmad_front #(
      .AVG_SAMPLES(AVG_SAMPLES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_accept   (in_accept),
      .sensor_word (req_sensor_word),
      .mode_b      (req_mode_b),
      .push        (push),
      .inflight    (inflight)
   );

   lmad_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .reserved (inflight),
      .pop      (pop),
      .head     (head),
      .status   (status)
   );

   lmad_back u_back (
      .clock               (clock),
      .reset               (reset),
      .limit               (limit_ff),
      .head                (head),
      .status              (status),
      .pop                 (pop),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_digit_thousands (rsp_digit_thousands),
      .rsp_digit_hundreds  (rsp_digit_hundreds),
      .rsp_digit_tens      (rsp_digit_tens),
      .rsp_digit_units     (rsp_digit_units),
      .rsp_decimal_point   (rsp_decimal_point),
      .rsp_overload        (rsp_overload)
   );

endmodule

// ===== sv/lmad_checker.sv =====
// port-level checks of the light meter core, bound to the top level
// depends on lmad_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmad_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [lmad_pkg::DIGIT_W-1:0]       rsp_digit_thousands,
   input logic [lmad_pkg::DIGIT_W-1:0]       rsp_digit_hundreds,
   input logic [lmad_pkg::DIGIT_W-1:0]       rsp_digit_tens,
   input logic [lmad_pkg::DIGIT_W-1:0]       rsp_digit_units,
   input logic                               rsp_decimal_point,
   input logic                               rsp_overload
);

   localparam int FIELDS_W = 4 * lmad_pkg::DIGIT_W + 2;

   logic                digits_blank;
   logic                digits_bcd;
   logic [FIELDS_W-1:0] rsp_fields;

   always_comb begin
      digits_blank = rsp_digit_thousands == '0 && rsp_digit_hundreds == '0
                     && rsp_digit_tens == '0 && rsp_digit_units == '0
                     && !rsp_decimal_point;
      digits_bcd   = rsp_digit_thousands <= 4'd9 && rsp_digit_hundreds <= 4'd9
                     && rsp_digit_tens <= 4'd9 && rsp_digit_units <= 4'd9;
      rsp_fields   = {rsp_digit_thousands, rsp_digit_hundreds, rsp_digit_tens,
                      rsp_digit_units, rsp_decimal_point, rsp_overload};
   end

   // no result right after reset
   `LMAD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid)

   // overload blanks the digits and the point
   `LMAD_ASSERT(a_ovl_blank, clock, reset, rsp_valid && rsp_overload |-> digits_blank)

   // every digit is bcd
   `LMAD_ASSERT(a_bcd, clock, reset, rsp_valid |-> digits_bcd)

   // a stalled item holds
   `LMAD_ASSERT(a_stall_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fields))

endmodule

bind light_meter_average_display_core lmad_checker u_lmad_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_digit_thousands (rsp_digit_thousands),
   .rsp_digit_hundreds  (rsp_digit_hundreds),
   .rsp_digit_tens      (rsp_digit_tens),
   .rsp_digit_units     (rsp_digit_units),
   .rsp_decimal_point   (rsp_decimal_point),
   .rsp_overload        (rsp_overload)
);

// ===== test/tb_top.sv =====
// testbench for light_meter_average_display_core: random and directed sensor words,
// random stalls on both sides, overload limit changes through the apb port
// depends on lmad_pkg and light_meter_average_display_core
`timescale 1ns / 1ps

typedef struct packed {
   logic [lmad_pkg::DIGIT_W-1:0] thousands;
   logic [lmad_pkg::DIGIT_W-1:0] hundreds;
   logic [lmad_pkg::DIGIT_W-1:0] tens;
   logic [lmad_pkg::DIGIT_W-1:0] units;
   logic                         point;
   logic                         overload;
} display_type;

localparam int AVG = lmad_pkg::AVG_SAMPLES_DEF;
localparam int LIMIT_INDEX = 0;
localparam logic [lmad_pkg::CSR_ADDR_W-1:0] LIMIT_ADDR =
   lmad_pkg::CSR_ADDR_W'(4 * LIMIT_INDEX);
localparam logic [lmad_pkg::LIMIT_W-1:0] LIMIT_MAX = '1;
localparam logic MODE_A = 1'b0;
localparam logic MODE_B = 1'b1;

class display_scoreboard;
   logic [lmad_pkg::READING_W-1:0] samples [AVG];
   int unsigned fill;
   logic [lmad_pkg::READING_W-1:0] held;
   logic [lmad_pkg::LIMIT_W-1:0] limit;
   display_type pending_displays [$];
   int unsigned mismatches;
   int unsigned accepted;
   int unsigned checked;
   int unsigned overloads;

   function new();
      foreach (samples[i]) samples[i] = '0;
      fill = 0;
      held = '0;
      limit = lmad_pkg::LIMIT_RESET;
      mismatches = 0;
      accepted = 0;
      checked = 0;
      overloads = 0;
   endfunction

   function void set_limit(logic [lmad_pkg::LIMIT_W-1:0] value);
      limit = value;
   endfunction

   // floor(mantissa * 2^exponent * 3 / 2500)
   function logic [lmad_pkg::READING_W-1:0] to_microwatts(logic [lmad_pkg::WORD_W-1:0] word);
      longint unsigned mant;
      longint unsigned scaled;
      mant = word[lmad_pkg::MANT_W-1:0];
      scaled = (mant << word[lmad_pkg::WORD_W-1:lmad_pkg::MANT_W]) * 3;
      return lmad_pkg::READING_W'(scaled / 2500);
   endfunction

   function void note_sample(logic [lmad_pkg::WORD_W-1:0] word, logic mode);
      logic [lmad_pkg::READING_W+1:0] sum;
      logic [lmad_pkg::READING_W-1:0] shown;
      display_type d;
      samples[fill] = to_microwatts(word);
      fill++;
      if (fill == AVG) begin
         sum = '0;
         foreach (samples[i]) sum += samples[i];
         held = lmad_pkg::READING_W'(sum / AVG);
         fill = 0;
      end
      accepted++;
      d = '0;
      if (held >= lmad_pkg::READING_W'(limit)) begin
         d.overload = 1'b1;
         overloads++;
      end else begin
         shown = (mode == MODE_B) ? held : (held >> 1);
         if (shown > 9999) shown = 9999;
         d.thousands = lmad_pkg::DIGIT_W'((shown / 1000) % 10);
         d.hundreds = lmad_pkg::DIGIT_W'((shown / 100) % 10);
         d.tens = lmad_pkg::DIGIT_W'((shown / 10) % 10);
         d.units = lmad_pkg::DIGIT_W'(shown % 10);
         d.point = (mode == MODE_A);
      end
      pending_displays.push_back(d);
   endfunction

   task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want)
         report_mismatch($sformatf("result %0d %s got %0d want %0d", checked, name, got, want));
   endtask

   task check_display(display_type got);
      display_type want;
      if (pending_displays.size() == 0) begin
         report_mismatch("result with no item waiting");
         return;
      end
      want = pending_displays.pop_front();
      compare_field("digit_thousands", got.thousands, want.thousands);
      compare_field("digit_hundreds", got.hundreds, want.hundreds);
      compare_field("digit_tens", got.tens, want.tens);
      compare_field("digit_units", got.units, want.units);
      compare_field("decimal_point", got.point, want.point);
      compare_field("overload", got.overload, want.overload);
      checked++;
   endtask
endclass

module tb_top;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [lmad_pkg::WORD_W-1:0] req_sensor_word = '0;
   logic req_mode_b = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [lmad_pkg::DIGIT_W-1:0] rsp_digit_thousands;
   logic [lmad_pkg::DIGIT_W-1:0] rsp_digit_hundreds;
   logic [lmad_pkg::DIGIT_W-1:0] rsp_digit_tens;
   logic [lmad_pkg::DIGIT_W-1:0] rsp_digit_units;
   logic rsp_decimal_point;
   logic rsp_overload;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [lmad_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [lmad_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [lmad_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   display_scoreboard sb = new();
   bit calm = 1'b0;
   int unsigned idle_cycles = 0;

   light_meter_average_display_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sensor_word(req_sensor_word),
      .req_mode_b(req_mode_b),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_digit_thousands(rsp_digit_thousands),
      .rsp_digit_hundreds(rsp_digit_hundreds),
      .rsp_digit_tens(rsp_digit_tens),
      .rsp_digit_units(rsp_digit_units),
      .rsp_decimal_point(rsp_decimal_point),
      .rsp_overload(rsp_overload),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #1 clock = ~clock;

   task automatic send_sample(input logic [lmad_pkg::WORD_W-1:0] word, input logic mode);
      req_valid <= 1'b1;
      req_sensor_word <= word;
      req_mode_b <= mode;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_sample(word, mode);
      if (!calm) begin
         while ($urandom_range(99) < 19) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending_displays.size() != 0) @(posedge clock);
   endtask

   task automatic check_limit(input logic [lmad_pkg::LIMIT_W-1:0] want);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= LIMIT_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== lmad_pkg::CSR_DATA_W'(want))
         sb.report_mismatch($sformatf("limit read got %0d want %0d", prdata, want));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic write_limit(input logic [lmad_pkg::LIMIT_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= LIMIT_ADDR;
      pwdata <= lmad_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.set_limit(value);
      @(posedge clock);
      check_limit(value);
   endtask

   // mostly words near a shared exponent so group means land in one range
   function automatic logic [lmad_pkg::WORD_W-1:0] random_word(input int unsigned base_exp);
      int unsigned e;
      if ($urandom_range(99) < 20) return lmad_pkg::WORD_W'($urandom);
      e = base_exp;
      if (e > 0 && $urandom_range(1) == 1) e = e - 1;
      return {lmad_pkg::EXP_W'(e), lmad_pkg::MANT_W'($urandom)};
   endfunction

   // result side: checks and random or long stalls
   initial begin
      int unsigned hold_left;
      bit hold_done;
      display_type got;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = '{rsp_digit_thousands, rsp_digit_hundreds, rsp_digit_tens,
                    rsp_digit_units, rsp_decimal_point, rsp_overload};
            sb.check_display(got);
         end
         if (!hold_done && sb.checked >= 400) begin
            hold_done = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 19);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 3000) begin
         $display("timeout: no item moved for %0d cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [lmad_pkg::WORD_W-1:0] directed_words [20];
      logic [lmad_pkg::LIMIT_W-1:0] limit_plan [6];
      int unsigned base_exp;
      directed_words = '{
         16'h0000, 16'hFFFF, 16'h0FFF, 16'hF000,
         16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
         16'hBFE5, 16'hBFE5, 16'hBFE5, 16'hBFE5,
         16'hBFE5, 16'hBFE5, 16'hBFE6, 16'hBFE6,
         16'hF001, 16'h0000, 16'h8555, 16'h7AAA};
      limit_plan = '{lmad_pkg::LIMIT_W'(1), lmad_pkg::LIMIT_W'(0), LIMIT_MAX,
                     lmad_pkg::LIMIT_RESET,
                     lmad_pkg::LIMIT_W'($urandom_range(1, 16383)),
                     lmad_pkg::LIMIT_W'($urandom_range(1, 2000))};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_limit(lmad_pkg::LIMIT_RESET);

      // zero and full scale, a mean of 9999 and a mean landing right on the limit
      for (int n = 0; n < 20; n++)
         send_sample(directed_words[n], (n % 2 == 0) ? MODE_A : MODE_B);

      base_exp = 0;
      for (int p = 0; p < 6; p++) begin
         drain_results();
         write_limit(limit_plan[p]);
         calm = (p == 2);
         for (int n = 0; n < 300; n++) begin
            if (n % 4 == 0) base_exp = $urandom_range(15);
            if (p == 4 && n == 150) drain_results();
            send_sample(random_word(base_exp), $urandom_range(1));
         end
      end
      calm = 1'b0;
      drain_results();
      repeat (20) @(posedge clock);
      if (sb.pending_displays.size() != 0)
         sb.report_mismatch($sformatf("%0d results never came", sb.pending_displays.size()));

      $display("run: %0d items sent, %0d results checked, %0d of them overload",
               sb.accepted, sb.checked, sb.overloads);
      $display("limits: reset, 1, 0, %0d, 10000, %0d, %0d; %0d mismatches",
               LIMIT_MAX, limit_plan[4], limit_plan[5], sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== light_meter_average_display_core.f =====
+incdir+sv
sv/lmad_pkg.sv
sv/lmad_front.sv
sv/lmad_queue.sv
sv/lmad_back.sv
sv/light_meter_average_display_core.sv
sv/lmad_checker.sv
test/tb_top.sv
